[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the XOR pair erasure recovery block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge, skipped while reset is low.
`define XPER_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define XPER_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define XPER_ASSERT(label, clk, rst_n, prop, msg)

`define XPER_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[rtl/xper_pkg.sv]
// Constants, command/status types and address helper for the pair recovery block.
package xper_pkg;

	localparam int FRAMES        = 4096;
	localparam int PAYLOAD_BYTES = 160;

	localparam int FRAME_IN_W  = 31;
	localparam int OUT_FRAME_W = 12;
	localparam int BYTE_W      = 8;
	localparam int POS_W       = 8;

	localparam int FRAME_W     = $clog2(FRAMES);
	localparam int PAIRS       = (FRAMES + 1) / 2;
	localparam int PAIR_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int STORE_DEPTH = FRAMES * PAYLOAD_BYTES;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// One flag entry per frame pair: data even, data odd, parity even, parity odd
	localparam int FLAG_W = 4;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic latch_a;
		logic rd_b;
		logic latch_b;
		logic decide;
		logic wr_b;
		logic byte1;
		logic byte2;
		logic advance;
	} xper_cmd_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic clr_last;
		logic pos_zero;
		logic need_b;
		logic write_b;
		logic recover;
		logic room;
	} xper_status_t;

	// Byte address of position pos within frame frame
	function automatic logic [STORE_AW-1:0] store_addr(input logic [FRAME_W-1:0] frame,
		input logic [POS_W-1:0] pos);
		return STORE_AW'(frame) * STORE_AW'(PAYLOAD_BYTES) + STORE_AW'(pos);
	endfunction

endpackage

[rtl/xor_pair_erasure_recovery.sv]
// Top level: XOR pair erasure recovery, sequencer plus datapath.
//
// Packets arrive one payload byte per transfer; the first byte of each packet
// looks up the present flags of the frame pair and decides whether the packet
// is dropped, stored and forwarded as data, or stored as parity, and whether a
// missing partner frame is rebuilt as parity XOR data. A byte has a transfer
// and a store step, and a rebuild step when it also rebuilds a byte,
// since the byte stores have one write and one registered read port each. The
// first byte of a packet adds flag memory steps: one read of
// the pair entry, a second read and write when an odd parity frame touches the
// next pair, and the decision write. After reset a clearing pass zeroes every
// pair entry of the flag memory before the first byte is taken. Results go
// through a four-entry queue, so input moves on while results wait and two
// entries are free; with two results from one byte the forwarded byte is first.
module xor_pair_erasure_recovery (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             parity_flag,
	input  logic [xper_pkg::FRAME_IN_W-1:0]  frame_number,
	input  logic [xper_pkg::BYTE_W-1:0]      payload_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [xper_pkg::OUT_FRAME_W-1:0] out_frame,
	output logic [xper_pkg::BYTE_W-1:0]      out_byte,
	output logic [xper_pkg::POS_W-1:0]       byte_index,
	output logic                             was_recovered,
	output logic                             last
);

	import xper_pkg::*;

	xper_cmd_t    cmd;
	xper_status_t st;

	// Sequencer
	xper_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	// Stores, decision and result queue
	xper_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.parity_flag  (parity_flag),
		.frame_number (frame_number),
		.payload_byte (payload_byte),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_frame    (out_frame),
		.out_byte     (out_byte),
		.byte_index   (byte_index),
		.was_recovered(was_recovered),
		.last         (last)
	);

endmodule

[rtl/xper_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module xper_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/xper_dp.sv]
// Datapath: flag and byte stores, packet decision, byte position and result queue.
module xper_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  xper_pkg::xper_cmd_t              cmd,
	output xper_pkg::xper_status_t           st,
	input  logic                             parity_flag,
	input  logic [xper_pkg::FRAME_IN_W-1:0]  frame_number,
	input  logic [xper_pkg::BYTE_W-1:0]      payload_byte,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [xper_pkg::OUT_FRAME_W-1:0] out_frame,
	output logic [xper_pkg::BYTE_W-1:0]      out_byte,
	output logic [xper_pkg::POS_W-1:0]       byte_index,
	output logic                             was_recovered,
	output logic                             last
);

	import xper_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [1:0] {
		ACT_DROP,
		ACT_DATA,
		ACT_PARITY
	} act_t;

	localparam int FL_DATA_ODD  = 1;
	localparam int FL_PAR_EVEN  = 2;
	localparam int OQ_DEPTH     = 4;
	localparam int OQ_AW        = $clog2(OQ_DEPTH);
	localparam int OQ_CW        = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic [OUT_FRAME_W-1:0] frame;
		logic [BYTE_W-1:0]      data;
		logic [POS_W-1:0]       idx;
		logic                   rec;
		logic                   fin;
	} res_t;

	// Latched input item
	logic               parity_q;
	logic [FRAME_W-1:0] frame_q;
	logic               inrange_q;
	logic [BYTE_W-1:0]  byte_q;

	// Packet state
	logic [FLAG_W-1:0]  a_q;
	logic [FLAG_W-1:0]  b_q;
	act_t               action_q;
	logic               recover_q;
	logic [FRAME_W-1:0] target_q;
	logic [FRAME_W-1:0] cur_q;
	logic [POS_W-1:0]   pos_q;
	logic [PAIR_W-1:0]  clr_q;

	// Result queue
	res_t               oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]   wp_q;
	logic [OQ_AW-1:0]   rp_q;
	logic [OQ_CW-1:0]   cnt_q;

	// Decision
	act_t               d_act;
	logic               d_rec;
	logic [FRAME_W-1:0] d_tgt;
	logic [FLAG_W-1:0]  a_new;
	logic               d_wr_b;
	logic               lsb;
	logic               partner_ok;
	logic               odd_ok;
	logic               even_has;
	logic               odd_has;

	// Memories
	logic               fl_we;
	logic [PAIR_W-1:0]  fl_waddr;
	logic [FLAG_W-1:0]  fl_wdata;
	logic [PAIR_W-1:0]  fl_raddr;
	logic [FLAG_W-1:0]  fl_rdata;
	logic [PAIR_W-1:0]  pair_a;
	logic [PAIR_W-1:0]  pair_b;

	logic                d_we;
	logic [STORE_AW-1:0] d_waddr;
	logic [BYTE_W-1:0]   d_wdata;
	logic [STORE_AW-1:0] d_raddr;
	logic [BYTE_W-1:0]   d_rdata;
	logic                p_we;
	logic [STORE_AW-1:0] p_waddr;
	logic [STORE_AW-1:0] p_raddr;
	logic [BYTE_W-1:0]   p_rdata;

	logic [FRAME_W-1:0] other_frame;
	logic [FRAME_W-1:0] even_frame;
	logic [BYTE_W-1:0]  rec_byte;
	logic               pos_last;
	logic               push;
	logic               pop;
	res_t               push_ent;

	// Classify the packet from the latched flag entries
	always_comb begin
		lsb        = frame_q[0];
		partner_ok = ((FRAME_W + 1)'(frame_q ^ FRAME_W'(1)) < (FRAME_W + 1)'(FRAMES));
		odd_ok     = ((FRAME_W + 1)'(frame_q) + (FRAME_W + 1)'(1) < (FRAME_W + 1)'(FRAMES));
		even_has   = a_q[lsb];
		odd_has    = odd_ok && (lsb ? b_q[0] : a_q[FL_DATA_ODD]);
		d_act      = ACT_DROP;
		d_rec      = 1'b0;
		d_tgt      = '0;
		a_new      = a_q;
		d_wr_b     = 1'b0;
		if (inrange_q) begin
			if (!parity_q) begin
				if (!a_q[lsb]) begin
					d_act      = ACT_DATA;
					a_new[lsb] = 1'b1;
					if (partner_ok && a_q[FL_PAR_EVEN] && !a_q[~lsb]) begin
						d_rec       = 1'b1;
						d_tgt       = frame_q ^ FRAME_W'(1);
						a_new[~lsb] = 1'b1;
					end
				end
			end else begin
				if (!a_q[{1'b1, lsb}]) begin
					d_act               = ACT_PARITY;
					a_new[{1'b1, lsb}] = 1'b1;
					if (even_has && !odd_has && odd_ok) begin
						d_rec = 1'b1;
						d_tgt = frame_q + FRAME_W'(1);
						if (lsb) begin
							d_wr_b = 1'b1;
						end else begin
							a_new[FL_DATA_ODD] = 1'b1;
						end
					end else if (!even_has && odd_has) begin
						d_rec      = 1'b1;
						d_tgt      = frame_q;
						a_new[lsb] = 1'b1;
					end
				end
			end
		end
	end

	// Flag memory: clearing pass, decision write, second pair write
	assign pair_a   = PAIR_W'(frame_q >> 1);
	assign pair_b   = pair_a + PAIR_W'(1);
	assign fl_raddr = cmd.rd_b ? pair_b : PAIR_W'(frame_number >> 1);

	always_comb begin
		fl_we    = 1'b0;
		fl_waddr = pair_a;
		fl_wdata = a_new;
		if (cmd.clr_wr) begin
			fl_we    = 1'b1;
			fl_waddr = clr_q;
			fl_wdata = '0;
		end else if (cmd.decide) begin
			fl_we = (d_act != ACT_DROP);
		end else if (cmd.wr_b) begin
			fl_we    = 1'b1;
			fl_waddr = pair_b;
			fl_wdata = b_q | FLAG_W'(1);
		end
	end

	xper_ram #(.WIDTH(FLAG_W), .DEPTH(PAIRS), .AW(PAIR_W)) u_flag_ram (
		.clk  (clk),
		.we   (fl_we),
		.waddr(fl_waddr),
		.wdata(fl_wdata),
		.raddr(fl_raddr),
		.rdata(fl_rdata)
	);

	// Byte stores
	assign other_frame = (target_q == cur_q) ? cur_q + FRAME_W'(1) : cur_q;
	assign even_frame  = {cur_q[FRAME_W-1:1], 1'b0};
	assign rec_byte    = ((action_q == ACT_DATA) ? p_rdata : d_rdata) ^ byte_q;

	assign d_we    = (cmd.byte1 && action_q == ACT_DATA) || cmd.byte2;
	assign d_waddr = store_addr(cmd.byte2 ? target_q : cur_q, pos_q);
	assign d_wdata = cmd.byte2 ? rec_byte : byte_q;
	assign d_raddr = store_addr(other_frame, pos_q);
	assign p_we    = cmd.byte1 && action_q == ACT_PARITY;
	assign p_waddr = store_addr(cur_q, pos_q);
	assign p_raddr = store_addr(even_frame, pos_q);

	xper_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH), .AW(STORE_AW)) u_data_ram (
		.clk  (clk),
		.we   (d_we),
		.waddr(d_waddr),
		.wdata(d_wdata),
		.raddr(d_raddr),
		.rdata(d_rdata)
	);

	xper_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH), .AW(STORE_AW)) u_parity_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(byte_q),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);

	// Result queue push and pop
	assign push = (cmd.byte1 && action_q == ACT_DATA) || cmd.byte2;
	assign pop  = out_valid && out_ready;

	always_comb begin
		push_ent.frame = OUT_FRAME_W'(cmd.byte2 ? target_q : cur_q);
		push_ent.data  = cmd.byte2 ? rec_byte : byte_q;
		push_ent.idx   = pos_q;
		push_ent.rec   = cmd.byte2;
		push_ent.fin   = cmd.byte2 || !recover_q;
	end

	assign pos_last = ((POS_W + 1)'(pos_q) + (POS_W + 1)'(1) >= (POS_W + 1)'(PAYLOAD_BYTES));

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			pos_q     <= '0;
			action_q  <= ACT_DROP;
			recover_q <= 1'b0;
			wp_q      <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + PAIR_W'(1);
			end
			if (cmd.decide) begin
				action_q  <= d_act;
				recover_q <= d_rec;
			end
			if (cmd.advance) begin
				pos_q <= pos_last ? '0 : pos_q + POS_W'(1);
			end
			if (push) begin
				wp_q <= wp_q + OQ_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + OQ_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OQ_CW'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - OQ_CW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			parity_q  <= parity_flag;
			frame_q   <= FRAME_W'(frame_number);
			inrange_q <= (frame_number < FRAME_IN_W'(FRAMES));
			byte_q    <= payload_byte;
		end
		if (cmd.latch_a) begin
			a_q <= fl_rdata;
		end
		if (cmd.latch_b) begin
			b_q <= fl_rdata;
		end
		if (cmd.decide) begin
			target_q <= d_tgt;
			cur_q    <= frame_q;
		end
		if (push) begin
			oq_q[wp_q] <= push_ent;
		end
	end

	// Status to the sequencer
	always_comb begin
		st.clr_last = (clr_q == PAIR_W'(PAIRS - 1));
		st.pos_zero = (pos_q == '0);
		st.need_b   = parity_q && lsb && inrange_q && odd_ok;
		st.write_b  = d_wr_b;
		st.recover  = recover_q;
		st.room     = (cnt_q <= OQ_CW'(OQ_DEPTH - 2));
	end

	// Output port
	assign out_valid     = (cnt_q != '0);
	assign out_frame     = oq_q[rp_q].frame;
	assign out_byte      = oq_q[rp_q].data;
	assign byte_index    = oq_q[rp_q].idx;
	assign was_recovered = oq_q[rp_q].rec;
	assign last          = oq_q[rp_q].fin;

	`XPER_ASSERT(a_oq_no_overflow, clk, arst_n, push |-> (cnt_q != OQ_CW'(OQ_DEPTH)) || pop, "result queue overflow")
	`XPER_ASSERT(a_rebuild_has_flag, clk, arst_n, cmd.byte2 |-> recover_q && (action_q != ACT_DROP), "rebuild without recovery decision")
	`XPER_ASSERT(a_fwd_then_rebuild, clk, arst_n, (cmd.byte1 && action_q == ACT_DATA && recover_q) |=> cmd.byte2, "forwarded byte not followed by rebuilt byte")

endmodule

[rtl/xper_ctrl.sv]
// Sequencer: clearing pass, flag lookup, decision and per-byte store steps.
module xper_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  xper_pkg::xper_status_t st,
	output xper_pkg::xper_cmd_t    cmd
);

	import xper_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_DECIDE,
		S_WR_B,
		S_BYTE1,
		S_BYTE2
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = st.room;
				if (in_valid && st.room) begin
					cmd.accept = 1'b1;
					state_d    = st.pos_zero ? S_RD_A : S_BYTE1;
				end
			end
			S_RD_A: begin
				cmd.latch_a = 1'b1;
				cmd.rd_b    = st.need_b;
				state_d     = st.need_b ? S_RD_B : S_DECIDE;
			end
			S_RD_B: begin
				cmd.latch_b = 1'b1;
				state_d     = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = st.write_b ? S_WR_B : S_BYTE1;
			end
			S_WR_B: begin
				cmd.wr_b = 1'b1;
				state_d  = S_BYTE1;
			end
			S_BYTE1: begin
				cmd.byte1 = 1'b1;
				if (st.recover) begin
					state_d = S_BYTE2;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_BYTE2: begin
				cmd.byte2   = 1'b1;
				cmd.advance = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`XPER_ASSERT(a_ready_has_room, clk, arst_n, in_ready |-> st.room, "input taken without queue room")
	`XPER_ASSERT_ALWAYS(a_no_ready_in_clear, clk, (state_q == S_CLEAR) |-> !in_ready, "input taken during clearing pass")

endmodule
